>>> rtl/rcfsa_pkg.sv
// Package for the RC frame checker and stick arming block.
// Holds the item structs, the internal command type and the register constants.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rcfsa_pkg;

  // Input item kinds as they arrive on the mode field.
  localparam logic [1:0] ModeFrameByte = 2'd0;
  localparam logic [1:0] ModeStickTick = 2'd1;
  localparam logic [1:0] ModeFailTick  = 2'd2;

  // Frame format.
  localparam logic [7:0] HdrFirst  = 8'hAA;
  localparam logic [7:0] HdrSecond = 8'hAF;
  // Position of the checksum byte in the shortest legal frame.
  localparam logic [7:0] MinEndPos = 8'd6;

  // Count limits.
  localparam logic [7:0] HoldSat = 8'd250;
  localparam logic [9:0] FsMax   = 10'd1023;

  // Channel slots in the committed channel array.
  localparam int unsigned ChRoll  = 0;
  localparam int unsigned ChPitch = 1;
  localparam int unsigned ChYaw   = 2;
  localparam int unsigned ChThr   = 3;
  localparam int unsigned NumCh   = 4;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegMinCheck  = 2'd0;
  localparam logic [1:0] RegMaxCheck  = 2'd1;
  localparam logic [1:0] RegHoldTicks = 2'd2;
  localparam logic [1:0] RegFsLimit   = 2'd3;

  // Register reset values.
  localparam logic [7:0] MinCheckRst  = 8'd20;
  localparam logic [7:0] MaxCheckRst  = 8'd235;
  localparam logic [7:0] HoldTicksRst = 8'd100;
  localparam logic [9:0] FsLimitRst   = 10'd500;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic       armed;
    logic       calibrate_pulse;
    logic       frame_accepted;
    logic       frame_rejected;
    logic       failsafe_trip;
    logic [7:0] roll_value;
    logic [7:0] pitch_value;
    logic [7:0] yaw_value;
    logic [7:0] throttle_value;
  } out_item_t;

  // Decoded command handed from the front end to the execution side.
  typedef enum logic [2:0] {
    OP_BYTE     = 3'd0,
    OP_END      = 3'd1,
    OP_STICK    = 3'd2,
    OP_FAILSAFE = 3'd3,
    OP_NONE     = 3'd4
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] min_check;
    logic [7:0] max_check;
    logic [7:0] hold_ticks;
    logic [9:0] failsafe_limit;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/rcfsa_front.sv
// Front end: accepts input beats and decodes them into commands.
// Depends on rcfsa_pkg for the item and command types.
`timescale 1ns / 1ps
`default_nettype none

module rcfsa_front (
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rcfsa_pkg::in_item_t in_data_i,
  output logic                   push_o,
  output rcfsa_pkg::cmd_t        cmd_o,
  input  wire logic              full_i
);

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // A frame byte splits into an ordinary byte and the closing checksum byte.
  always_comb begin
    cmd_o.data = in_data_i.frame_byte;
    unique case (in_data_i.mode)
      rcfsa_pkg::ModeFrameByte: begin
        cmd_o.op = in_data_i.frame_end ? rcfsa_pkg::OP_END : rcfsa_pkg::OP_BYTE;
      end
      rcfsa_pkg::ModeStickTick: begin
        cmd_o.op = rcfsa_pkg::OP_STICK;
      end
      rcfsa_pkg::ModeFailTick: begin
        cmd_o.op = rcfsa_pkg::OP_FAILSAFE;
      end
      default: begin
        cmd_o.op = rcfsa_pkg::OP_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/rcfsa_queue.sv
// Two-entry command queue between the front end and the execution side.
// Depends on rcfsa_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module rcfsa_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire rcfsa_pkg::cmd_t cmd_i,
  output logic                 full_o,
  output logic                 empty_o,
  input  wire logic            pop_i,
  output rcfsa_pkg::cmd_t      cmd_o
);

  rcfsa_pkg::cmd_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rcfsa_back.sv
// Execution side: frame checker, stick gesture logic, failsafe timer and
// the result register. Depends on rcfsa_pkg for command, config and item types.
`timescale 1ns / 1ps
`default_nettype none

module rcfsa_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rcfsa_pkg::cfg_t  cfg_i,
  input  wire logic             empty_i,
  input  wire rcfsa_pkg::cmd_t  cmd_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output rcfsa_pkg::out_item_t  out_data_o
);

  logic [7:0] pos_q, pos_d;
  logic [7:0] sum_q, sum_d;
  logic       hdr_q, hdr_d;
  logic [7:0] staged_q [rcfsa_pkg::NumCh];
  logic [7:0] ch_q [rcfsa_pkg::NumCh];
  logic [7:0] ch_d [rcfsa_pkg::NumCh];
  logic [7:0] hold_q, hold_d;
  logic [9:0] fs_q, fs_d;
  logic       armed_q, armed_d;
  logic       out_valid_q, out_valid_d;
  rcfsa_pkg::out_item_t out_q, res;

  logic                        take;
  logic                        stage_we;
  logic [1:0]                  stage_idx;
  logic [rcfsa_pkg::NumCh-1:0] lo, hi;
  logic [7:0]                  hold_cnt;
  logic [9:0]                  fs_cnt;

  // A command moves on whenever the result register is free or being drained.
  assign take        = !empty_i && (!out_valid_q || out_ready_i);
  assign pop_o       = take;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Stick flags always come from the committed channels.
  always_comb begin
    for (int i = 0; i < rcfsa_pkg::NumCh; i++) begin
      lo[i] = ch_q[i] < cfg_i.min_check;
      hi[i] = ch_q[i] > cfg_i.max_check;
    end
  end

  assign stage_idx = pos_q[1:0] - 2'd2;

  always_comb begin
    pos_d     = pos_q;
    sum_d     = sum_q;
    hdr_d     = hdr_q;
    ch_d      = ch_q;
    hold_d    = hold_q;
    fs_d      = fs_q;
    armed_d   = armed_q;
    stage_we  = 1'b0;
    hold_cnt  = hold_q;
    fs_cnt    = fs_q;
    res       = '0;

    unique case (cmd_i.op)
      rcfsa_pkg::OP_BYTE: begin
        if (pos_q == 8'd0) begin
          hdr_d = hdr_q && (cmd_i.data == rcfsa_pkg::HdrFirst);
        end else if (pos_q == 8'd1) begin
          hdr_d = hdr_q && (cmd_i.data == rcfsa_pkg::HdrSecond);
        end else if (pos_q <= 8'd5) begin
          stage_we = 1'b1;
        end
        sum_d = sum_q + cmd_i.data;
        if (pos_q != 8'hFF) begin
          pos_d = pos_q + 8'd1;
        end
      end
      rcfsa_pkg::OP_END: begin
        if (pos_q >= rcfsa_pkg::MinEndPos && hdr_q && cmd_i.data == sum_q) begin
          ch_d[rcfsa_pkg::ChYaw]   = ~staged_q[0];
          ch_d[rcfsa_pkg::ChThr]   = ~staged_q[1];
          ch_d[rcfsa_pkg::ChPitch] = ~staged_q[2];
          ch_d[rcfsa_pkg::ChRoll]  = ~staged_q[3];
          fs_d                     = 10'd0;
          res.frame_accepted       = 1'b1;
        end else begin
          res.frame_rejected = 1'b1;
        end
        pos_d = 8'd0;
        sum_d = 8'd0;
        hdr_d = 1'b1;
      end
      rcfsa_pkg::OP_STICK: begin
        if (|(lo | hi)) begin
          if (hold_q < rcfsa_pkg::HoldSat) begin
            hold_cnt = hold_q + 8'd1;
          end
        end else begin
          hold_cnt = 8'd0;
        end
        hold_d = hold_cnt;
        if (hold_cnt == cfg_i.hold_ticks) begin
          if (armed_q) begin
            if (&lo) begin
              armed_d = 1'b0;
            end
          end else if (hi[rcfsa_pkg::ChYaw] && lo[rcfsa_pkg::ChThr]) begin
            armed_d = 1'b1;
          end
          res.calibrate_pulse = lo[rcfsa_pkg::ChYaw] && hi[rcfsa_pkg::ChThr] &&
                                hi[rcfsa_pkg::ChRoll] && lo[rcfsa_pkg::ChPitch];
          hold_d = 8'd0;
        end
      end
      rcfsa_pkg::OP_FAILSAFE: begin
        if (fs_q > cfg_i.failsafe_limit) begin
          fs_cnt            = 10'd0;
          armed_d           = 1'b0;
          res.failsafe_trip = 1'b1;
        end
        fs_d = (fs_cnt != rcfsa_pkg::FsMax) ? fs_cnt + 10'd1 : fs_cnt;
      end
      default: begin
      end
    endcase

    res.armed          = armed_d;
    res.roll_value     = ch_d[rcfsa_pkg::ChRoll];
    res.pitch_value    = ch_d[rcfsa_pkg::ChPitch];
    res.yaw_value      = ch_d[rcfsa_pkg::ChYaw];
    res.throttle_value = ch_d[rcfsa_pkg::ChThr];

    out_valid_d = take || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 8'd0;
      sum_q       <= 8'd0;
      hdr_q       <= 1'b1;
      hold_q      <= 8'd0;
      fs_q        <= 10'd0;
      armed_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < rcfsa_pkg::NumCh; i++) begin
        ch_q[i] <= 8'd0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        pos_q   <= pos_d;
        sum_q   <= sum_d;
        hdr_q   <= hdr_d;
        hold_q  <= hold_d;
        fs_q    <= fs_d;
        armed_q <= armed_d;
        ch_q    <= ch_d;
      end
    end
  end

  // Staged channel bytes and the result payload carry no reset.
  always_ff @(posedge clk_i) begin
    if (take && stage_we) begin
      staged_q[stage_idx] <= cmd_i.data;
    end
    if (take) begin
      out_q <= res;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rc_frame_stick_arming_core.sv
// Top level of the RC frame checker with stick arming and failsafe.
// Depends on rcfsa_pkg, rcfsa_front, rcfsa_queue and rcfsa_back.
//
// Usage: every input beat carries a mode (frame byte, stick tick or failsafe
// tick), a frame byte and a frame end marker. Every accepted beat yields
// exactly one result beat with the armed state, the event pulses and the
// four committed channel values, in order.
// Both channels use a valid/ready handshake. The front end decodes each beat
// into a command and writes it into a two-entry queue; the back end takes one
// command per cycle while the result register is free or being drained,
// updates its state and loads the result register. An accepted beat is first
// written into the queue; its command is then loaded into the result register,
// which presents the result beat.
// Throughput: one beat per cycle, sustained, as long as the receiver takes
// results; every command is finished by the back end as it is taken.
// When the receiver stalls, the result register holds its beat, the back end
// stops, and the queue absorbs up to two more beats before in_ready_o drops.
// Reset clears the frame checker, the committed channels, the counters and
// the armed flag, empties the queue and loads the register reset values.
// Registers sit on an APB-style port at byte addresses 0, 4, 8 and 12 and
// should be written only while no beat is in flight.
`timescale 1ns / 1ps
`default_nettype none

module rc_frame_stick_arming_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire rcfsa_pkg::in_item_t  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output rcfsa_pkg::out_item_t      out_data_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [3:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  rcfsa_pkg::cfg_t cfg_q;
  logic [1:0]      reg_idx;
  logic            reg_we;

  logic            push;
  logic            full;
  logic            empty;
  logic            pop;
  rcfsa_pkg::cmd_t front_cmd;
  rcfsa_pkg::cmd_t back_cmd;

  // Register file. The port never inserts wait states.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign reg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_check      <= rcfsa_pkg::MinCheckRst;
      cfg_q.max_check      <= rcfsa_pkg::MaxCheckRst;
      cfg_q.hold_ticks     <= rcfsa_pkg::HoldTicksRst;
      cfg_q.failsafe_limit <= rcfsa_pkg::FsLimitRst;
    end else if (reg_we) begin
      unique case (reg_idx)
        rcfsa_pkg::RegMinCheck:  cfg_q.min_check      <= pwdata[7:0];
        rcfsa_pkg::RegMaxCheck:  cfg_q.max_check      <= pwdata[7:0];
        rcfsa_pkg::RegHoldTicks: cfg_q.hold_ticks     <= pwdata[7:0];
        rcfsa_pkg::RegFsLimit:   cfg_q.failsafe_limit <= pwdata[9:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rcfsa_pkg::RegMinCheck:  prdata = {24'd0, cfg_q.min_check};
      rcfsa_pkg::RegMaxCheck:  prdata = {24'd0, cfg_q.max_check};
      rcfsa_pkg::RegHoldTicks: prdata = {24'd0, cfg_q.hold_ticks};
      rcfsa_pkg::RegFsLimit:   prdata = {22'd0, cfg_q.failsafe_limit};
      default:                 prdata = 32'd0;
    endcase
  end

  // Decode incoming beats into commands.
  rcfsa_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .cmd_o      (front_cmd),
    .full_i     (full)
  );

  // Decouples acceptance from execution so each side can stall on its own.
  rcfsa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .empty_o (empty),
    .pop_i   (pop),
    .cmd_o   (back_cmd)
  );

  // Frame checker, gesture logic, failsafe timer and the result register.
  rcfsa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .cmd_i       (back_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
